// ===== hw/rtl/rtn_pkg.sv =====
// shared types, constants and the multiply-accumulate program of the ray/triangle core
package rtn_pkg;

	localparam int FRAC_BITS = 16;
	// edge and offset width
	localparam int CW = 33;
	// cross product width
	localparam int PV_W = 68;
	// accumulator and numerator width, holds min_distance * det and det << 31
	localparam int W = 136;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [W-1:0] acc_t;

	typedef struct packed {
		logic [2:0][31:0] origin;
		logic [2:0][31:0] dir;
		logic [31:0]      det_thr;
		logic [30:0]      min_dist;
	} cfg_t;

	typedef struct packed {
		coord_t [2:0] e1;
		coord_t [2:0] e2;
		coord_t [2:0] tv;
		logic [15:0]  id;
		logic         last;
	} tri_t;

	typedef enum logic [2:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_DIR_X    = 3'd3,
		REG_DIR_Y    = 3'd4,
		REG_DIR_Z    = 3'd5,
		REG_DET_THR  = 3'd6,
		REG_MIN_DIST = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		SRC_D0, SRC_D1, SRC_D2,
		SRC_E1_0, SRC_E1_1, SRC_E1_2,
		SRC_E2_0, SRC_E2_1, SRC_E2_2,
		SRC_TV0, SRC_TV1, SRC_TV2,
		SRC_MD
	} mpl_src_t;

	typedef enum logic [3:0] {
		MCD_E1_0, MCD_E1_1, MCD_E1_2,
		MCD_E2_0, MCD_E2_1, MCD_E2_2,
		MCD_PV0, MCD_PV1, MCD_PV2,
		MCD_QV0, MCD_QV1, MCD_QV2,
		MCD_DET
	} mcd_src_t;

	typedef enum logic [3:0] {
		DST_NONE,
		DST_PV0, DST_PV1, DST_PV2,
		DST_QV0, DST_QV1, DST_QV2,
		DST_DET, DST_UN, DST_VN, DST_TN,
		DST_MD
	} dst_t;

	typedef struct packed {
		mpl_src_t mpl;
		mcd_src_t mcd;
		logic     neg;
		logic     clr;
		dst_t     dst;
	} mop_t;

	typedef struct packed {
		logic start;
		logic clear;
		logic neg;
	} mac_cmd_t;

	localparam logic [4:0] OP_LAST_VEC = 5'd23;
	localparam logic [4:0] OP_MD       = 5'd24;

	// program: pv = d x e2, qv = tv x e1, det/un/vn/tn dot products, then min_distance * det
	function automatic mop_t mop_decode(input logic [4:0] op);
		mop_t m;
		case (op)
			5'd0:  m = '{SRC_D1,   MCD_E2_2, 1'b0, 1'b1, DST_NONE};
			5'd1:  m = '{SRC_D2,   MCD_E2_1, 1'b1, 1'b0, DST_PV0};
			5'd2:  m = '{SRC_D2,   MCD_E2_0, 1'b0, 1'b1, DST_NONE};
			5'd3:  m = '{SRC_D0,   MCD_E2_2, 1'b1, 1'b0, DST_PV1};
			5'd4:  m = '{SRC_D0,   MCD_E2_1, 1'b0, 1'b1, DST_NONE};
			5'd5:  m = '{SRC_D1,   MCD_E2_0, 1'b1, 1'b0, DST_PV2};
			5'd6:  m = '{SRC_TV1,  MCD_E1_2, 1'b0, 1'b1, DST_NONE};
			5'd7:  m = '{SRC_TV2,  MCD_E1_1, 1'b1, 1'b0, DST_QV0};
			5'd8:  m = '{SRC_TV2,  MCD_E1_0, 1'b0, 1'b1, DST_NONE};
			5'd9:  m = '{SRC_TV0,  MCD_E1_2, 1'b1, 1'b0, DST_QV1};
			5'd10: m = '{SRC_TV0,  MCD_E1_1, 1'b0, 1'b1, DST_NONE};
			5'd11: m = '{SRC_TV1,  MCD_E1_0, 1'b1, 1'b0, DST_QV2};
			5'd12: m = '{SRC_E1_0, MCD_PV0,  1'b0, 1'b1, DST_NONE};
			5'd13: m = '{SRC_E1_1, MCD_PV1,  1'b0, 1'b0, DST_NONE};
			5'd14: m = '{SRC_E1_2, MCD_PV2,  1'b0, 1'b0, DST_DET};
			5'd15: m = '{SRC_TV0,  MCD_PV0,  1'b0, 1'b1, DST_NONE};
			5'd16: m = '{SRC_TV1,  MCD_PV1,  1'b0, 1'b0, DST_NONE};
			5'd17: m = '{SRC_TV2,  MCD_PV2,  1'b0, 1'b0, DST_UN};
			5'd18: m = '{SRC_D0,   MCD_QV0,  1'b0, 1'b1, DST_NONE};
			5'd19: m = '{SRC_D1,   MCD_QV1,  1'b0, 1'b0, DST_NONE};
			5'd20: m = '{SRC_D2,   MCD_QV2,  1'b0, 1'b0, DST_VN};
			5'd21: m = '{SRC_E2_0, MCD_QV0,  1'b0, 1'b1, DST_NONE};
			5'd22: m = '{SRC_E2_1, MCD_QV1,  1'b0, 1'b0, DST_NONE};
			5'd23: m = '{SRC_E2_2, MCD_QV2,  1'b0, 1'b0, DST_TN};
			5'd24: m = '{SRC_MD,   MCD_DET,  1'b0, 1'b1, DST_MD};
			default: m = '{SRC_D0, MCD_E1_0, 1'b0, 1'b0, DST_NONE};
		endcase
		return m;
	endfunction

endpackage

// ===== hw/rtl/rtn_front.sv =====
// front end: takes triangle beats, forms edges and origin offset, two-entry queue
module rtn_front (
	input  logic               clk,
	input  logic               arst_n,
	input  rtn_pkg::cfg_t      cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0][31:0]   vtx_a,
	input  logic [2:0][31:0]   vtx_b,
	input  logic [2:0][31:0]   vtx_c,
	input  logic [15:0]        triangle_id,
	input  logic               group_last,
	output logic               q_valid,
	output rtn_pkg::tri_t      q_entry,
	input  logic               q_pop
);
	import rtn_pkg::*;

	tri_t       ent;
	tri_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;

	// edges b-a, c-a and offset origin-a, 33 bits each
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ent.e1[i] = {vtx_b[i][31], vtx_b[i]} - {vtx_a[i][31], vtx_a[i]};
			ent.e2[i] = {vtx_c[i][31], vtx_c[i]} - {vtx_a[i][31], vtx_a[i]};
			ent.tv[i] = {cfg.origin[i][31], cfg.origin[i]} - {vtx_a[i][31], vtx_a[i]};
		end
		ent.id   = triangle_id;
		ent.last = group_last;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_entry  = ent_q[rd_q];

	// queue pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= ent;
	end

endmodule

// ===== hw/rtl/rtn_mac.sv =====
// serial multiply-accumulate: one multiplier bit per cycle, 33-bit signed multiplier
module rtn_mac (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rtn_pkg::mac_cmd_t          cmd,
	input  logic signed [32:0]         mplier,
	input  logic signed [rtn_pkg::W-1:0] mcand,
	output logic                       busy,
	output logic                       done,
	output logic signed [rtn_pkg::W-1:0] acc
);
	import rtn_pkg::*;

	localparam logic [5:0] LAST_BIT = 6'(CW - 1);

	logic              busy_q;
	logic              done_q;
	logic [5:0]        cnt_q;
	logic              neg_q;
	logic [CW-1:0]     mpl_q;
	acc_t              sh_q;
	acc_t              acc_q;
	logic              sub;

	// top bit of a signed multiplier weighs negative
	assign sub = neg_q ^ (cnt_q == LAST_BIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
			mpl_q  <= '0;
			sh_q   <= '0;
			acc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				neg_q  <= cmd.neg;
				mpl_q  <= mplier;
				sh_q   <= mcand;
				if (cmd.clear) acc_q <= '0;
			end else if (busy_q) begin
				if (mpl_q[0]) acc_q <= sub ? (acc_q - sh_q) : (acc_q + sh_q);
				mpl_q <= mpl_q >> 1;
				sh_q  <= sh_q << 1;
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == LAST_BIT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign acc  = acc_q;

endmodule

// ===== hw/rtl/rtn_back.sv =====
// back end: sequencer over the mac, range checks, t division, nearest-hit reduce, output reg
module rtn_back #(
	parameter int ID_WIDTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  rtn_pkg::cfg_t   cfg,
	input  logic            q_valid,
	input  rtn_pkg::tri_t   q_entry,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            hit,
	output logic [30:0]     hit_distance,
	output logic            nearest_found,
	output logic [30:0]     nearest_distance,
	output logic [15:0]     nearest_id,
	output logic            group_done
);
	import rtn_pkg::*;

	localparam int IDW = (ID_WIDTH < 16) ? ID_WIDTH : 16;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_MUL  = 8'b0000_0010,
		S_NORM = 8'b0000_0100,
		S_CHK  = 8'b0000_1000,
		S_CHK2 = 8'b0001_0000,
		S_TCHK = 8'b0010_0000,
		S_DIV  = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t                  state_q;
	tri_t                    tri_q;
	logic [4:0]              op_q;
	logic                    pend_q;
	logic signed [PV_W-1:0]  pv_q [3];
	logic signed [PV_W-1:0]  qv_q [3];
	acc_t                    det_q, un_q, vn_q, tn_q, md_q;
	acc_t                    rem_q, dd_q;
	logic [4:0]              k_q;
	logic                    hit_q;
	logic [30:0]             tq_q;
	logic                    best_valid_q;
	logic [30:0]             best_dist_q;
	logic [IDW-1:0]          best_id_q;
	logic                    out_valid_q;
	logic                    hit_out_q;
	logic [30:0]             dist_out_q;
	logic                    found_out_q;
	logic [30:0]             ndist_out_q;
	logic [15:0]             nid_out_q;
	logic                    done_out_q;

	mop_t                    mop;
	mac_cmd_t                mcmd;
	logic signed [CW-1:0]    mpl;
	acc_t                    mcd;
	logic                    mac_busy, mac_done;
	acc_t                    mac_acc;
	acc_t                    thr, sum, nn, lim;
	logic                    load;
	logic [30:0]             t_now;
	logic                    upd;
	logic                    nb_valid;
	logic [30:0]             nb_dist;
	logic [IDW-1:0]          nb_id;

	// operand selection for the current program step
	assign mop = mop_decode(op_q);

	always_comb begin
		case (mop.mpl)
			SRC_D0:   mpl = {cfg.dir[0][31], cfg.dir[0]};
			SRC_D1:   mpl = {cfg.dir[1][31], cfg.dir[1]};
			SRC_D2:   mpl = {cfg.dir[2][31], cfg.dir[2]};
			SRC_E1_0: mpl = tri_q.e1[0];
			SRC_E1_1: mpl = tri_q.e1[1];
			SRC_E1_2: mpl = tri_q.e1[2];
			SRC_E2_0: mpl = tri_q.e2[0];
			SRC_E2_1: mpl = tri_q.e2[1];
			SRC_E2_2: mpl = tri_q.e2[2];
			SRC_TV0:  mpl = tri_q.tv[0];
			SRC_TV1:  mpl = tri_q.tv[1];
			SRC_TV2:  mpl = tri_q.tv[2];
			SRC_MD:   mpl = {2'b00, cfg.min_dist};
			default:  mpl = '0;
		endcase
	end

	always_comb begin
		case (mop.mcd)
			MCD_E1_0: mcd = W'(tri_q.e1[0]);
			MCD_E1_1: mcd = W'(tri_q.e1[1]);
			MCD_E1_2: mcd = W'(tri_q.e1[2]);
			MCD_E2_0: mcd = W'(tri_q.e2[0]);
			MCD_E2_1: mcd = W'(tri_q.e2[1]);
			MCD_E2_2: mcd = W'(tri_q.e2[2]);
			MCD_PV0:  mcd = W'(pv_q[0]);
			MCD_PV1:  mcd = W'(pv_q[1]);
			MCD_PV2:  mcd = W'(pv_q[2]);
			MCD_QV0:  mcd = W'(qv_q[0]);
			MCD_QV1:  mcd = W'(qv_q[1]);
			MCD_QV2:  mcd = W'(qv_q[2]);
			MCD_DET:  mcd = det_q;
			default:  mcd = '0;
		endcase
	end

	assign mcmd.start = (state_q == S_MUL) && pend_q;
	assign mcmd.clear = mop.clr;
	assign mcmd.neg   = mop.neg;

	rtn_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mcmd),
		.mplier (mpl),
		.mcand  (mcd),
		.busy   (mac_busy),
		.done   (mac_done),
		.acc    (mac_acc)
	);

	// threshold and t compare operands
	assign thr = W'(cfg.det_thr) << (2 * FRAC_BITS);
	assign sum = un_q + vn_q;
	assign nn  = tn_q <<< FRAC_BITS;
	assign lim = det_q <<< 31;

	assign q_pop = (state_q == S_IDLE) && q_valid;

	// nearest-hit reduce at output load
	assign load     = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign t_now    = hit_q ? tq_q : 31'd0;
	assign upd      = hit_q && (!best_valid_q || (t_now < best_dist_q));
	assign nb_valid = best_valid_q | upd;
	assign nb_dist  = upd ? t_now : best_dist_q;
	assign nb_id    = upd ? tri_q.id[IDW-1:0] : best_id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			tri_q        <= '0;
			op_q         <= '0;
			pend_q       <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				pv_q[i] <= '0;
				qv_q[i] <= '0;
			end
			det_q        <= '0;
			un_q         <= '0;
			vn_q         <= '0;
			tn_q         <= '0;
			md_q         <= '0;
			rem_q        <= '0;
			dd_q         <= '0;
			k_q          <= '0;
			hit_q        <= 1'b0;
			tq_q         <= '0;
			best_valid_q <= 1'b0;
			best_dist_q  <= '0;
			best_id_q    <= '0;
			out_valid_q  <= 1'b0;
			hit_out_q    <= 1'b0;
			dist_out_q   <= '0;
			found_out_q  <= 1'b0;
			ndist_out_q  <= '0;
			nid_out_q    <= '0;
			done_out_q   <= 1'b0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						tri_q   <= q_entry;
						op_q    <= '0;
						pend_q  <= 1'b1;
						hit_q   <= 1'b0;
						tq_q    <= '0;
						state_q <= S_MUL;
					end
				end
				// one program step per mac pass
				S_MUL: begin
					if (pend_q) begin
						pend_q <= 1'b0;
					end else if (mac_done) begin
						case (mop.dst)
							DST_PV0: pv_q[0] <= mac_acc[PV_W-1:0];
							DST_PV1: pv_q[1] <= mac_acc[PV_W-1:0];
							DST_PV2: pv_q[2] <= mac_acc[PV_W-1:0];
							DST_QV0: qv_q[0] <= mac_acc[PV_W-1:0];
							DST_QV1: qv_q[1] <= mac_acc[PV_W-1:0];
							DST_QV2: qv_q[2] <= mac_acc[PV_W-1:0];
							DST_DET: det_q <= mac_acc;
							DST_UN:  un_q  <= mac_acc;
							DST_VN:  vn_q  <= mac_acc;
							DST_TN:  tn_q  <= mac_acc;
							DST_MD:  md_q  <= mac_acc;
							default: ;
						endcase
						if (op_q == OP_LAST_VEC) begin
							state_q <= S_NORM;
						end else if (op_q == OP_MD) begin
							state_q <= S_TCHK;
						end else begin
							op_q   <= op_q + 5'd1;
							pend_q <= 1'b1;
						end
					end
				end
				// degenerate reject, make det positive
				S_NORM: begin
					if (det_q == '0) begin
						state_q <= S_DONE;
					end else begin
						if (det_q[W-1]) begin
							det_q <= -det_q;
							un_q  <= -un_q;
							vn_q  <= -vn_q;
							tn_q  <= -tn_q;
						end
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if ((det_q < thr) || un_q[W-1] || (det_q < un_q)) state_q <= S_DONE;
					else state_q <= S_CHK2;
				end
				S_CHK2: begin
					if (vn_q[W-1] || (det_q < sum)) begin
						state_q <= S_DONE;
					end else begin
						op_q    <= OP_MD;
						pend_q  <= 1'b1;
						state_q <= S_MUL;
					end
				end
				// min distance, far saturation, else divide
				S_TCHK: begin
					if (nn < md_q) begin
						state_q <= S_DONE;
					end else if (nn >= lim) begin
						hit_q   <= 1'b1;
						tq_q    <= '1;
						state_q <= S_DONE;
					end else begin
						rem_q   <= nn;
						dd_q    <= det_q <<< 30;
						k_q     <= 5'd30;
						state_q <= S_DIV;
					end
				end
				// restoring division, one quotient bit per cycle
				S_DIV: begin
					if (rem_q >= dd_q) begin
						rem_q     <= rem_q - dd_q;
						tq_q[k_q] <= 1'b1;
					end
					dd_q <= dd_q >>> 1;
					if (k_q == 5'd0) begin
						hit_q   <= 1'b1;
						state_q <= S_DONE;
					end else begin
						k_q <= k_q - 5'd1;
					end
				end
				S_DONE: begin
					if (load) begin
						hit_out_q   <= hit_q;
						dist_out_q  <= t_now;
						found_out_q <= nb_valid;
						ndist_out_q <= nb_dist;
						nid_out_q   <= 16'(nb_id);
						done_out_q  <= tri_q.last;
						if (tri_q.last) begin
							best_valid_q <= 1'b0;
							best_dist_q  <= '0;
							best_id_q    <= '0;
						end else begin
							best_valid_q <= nb_valid;
							best_dist_q  <= nb_dist;
							best_id_q    <= nb_id;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign hit              = hit_out_q;
	assign hit_distance     = dist_out_q;
	assign nearest_found    = found_out_q;
	assign nearest_distance = ndist_out_q;
	assign nearest_id       = nid_out_q;
	assign group_done       = done_out_q;

	a_mac_free: assert property (@(posedge clk) disable iff (!arst_n)
		mcmd.start |-> !mac_busy)
		else $error("mac started while busy");
	a_op_range: assert property (@(posedge clk) disable iff (!arst_n)
		op_q <= OP_MD)
		else $error("program step out of range");
	a_best_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> $stable(best_dist_q) && $stable(best_valid_q))
		else $error("nearest state moved while output stalled");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !hit_out_q) |-> (dist_out_q == 31'd0))
		else $error("miss beat with nonzero distance");

endmodule

// ===== hw/rtl/ray_triangle_nearest_hit_core.sv =====
// top level of the ray/triangle nearest-hit core: config registers, front, back
//
// channel   direction  handshake               payload
// cfg       in         cfg_write               cfg_index, cfg_data
// in        in         in_valid / in_ready     vertex_{a,b,c}_{x,y,z}, triangle_id, group_last
// out       out        out_valid / out_ready   hit, hit_distance, nearest_*, group_done
//
// the time per triangle is set by the serial multiply-accumulate unit: 25 multiplies of one
// multiplier bit per cycle, plus a restoring division for t; an early reject skips the tail.
// arst_n clears control and the nearest-hit state and sets the config registers to defaults:
// origin zero, direction +z, det threshold and min distance one.
// a two-beat queue lets the next triangle land while one is in work; the output
// register lets work finish while out_ready is low.
module ray_triangle_nearest_hit_core #(
	parameter int ID_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] vertex_a_x,
	input  logic [31:0] vertex_a_y,
	input  logic [31:0] vertex_a_z,
	input  logic [31:0] vertex_b_x,
	input  logic [31:0] vertex_b_y,
	input  logic [31:0] vertex_b_z,
	input  logic [31:0] vertex_c_x,
	input  logic [31:0] vertex_c_y,
	input  logic [31:0] vertex_c_z,
	input  logic [15:0] triangle_id,
	input  logic        group_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit,
	output logic [30:0] hit_distance,
	output logic        nearest_found,
	output logic [30:0] nearest_distance,
	output logic [15:0] nearest_id,
	output logic        group_done
);
	import rtn_pkg::*;

	cfg_t  cfg_q;
	logic  q_valid;
	tri_t  q_entry;
	logic  q_pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin   <= '0;
			cfg_q.dir[0]   <= '0;
			cfg_q.dir[1]   <= '0;
			cfg_q.dir[2]   <= 32'h0001_0000;
			cfg_q.det_thr  <= 32'd1;
			cfg_q.min_dist <= 31'd1;
		end else if (cfg_write) begin
			case (reg_idx_t'(cfg_index))
				REG_ORIGIN_X: cfg_q.origin[0] <= cfg_data;
				REG_ORIGIN_Y: cfg_q.origin[1] <= cfg_data;
				REG_ORIGIN_Z: cfg_q.origin[2] <= cfg_data;
				REG_DIR_X:    cfg_q.dir[0]    <= cfg_data;
				REG_DIR_Y:    cfg_q.dir[1]    <= cfg_data;
				REG_DIR_Z:    cfg_q.dir[2]    <= cfg_data;
				REG_DET_THR:  cfg_q.det_thr   <= cfg_data;
				REG_MIN_DIST: cfg_q.min_dist  <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	rtn_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.vtx_a       ({vertex_a_z, vertex_a_y, vertex_a_x}),
		.vtx_b       ({vertex_b_z, vertex_b_y, vertex_b_x}),
		.vtx_c       ({vertex_c_z, vertex_c_y, vertex_c_x}),
		.triangle_id (triangle_id),
		.group_last  (group_last),
		.q_valid     (q_valid),
		.q_entry     (q_entry),
		.q_pop       (q_pop)
	);

	rtn_back #(
		.ID_WIDTH (ID_WIDTH)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.q_valid          (q_valid),
		.q_entry          (q_entry),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.hit              (hit),
		.hit_distance     (hit_distance),
		.nearest_found    (nearest_found),
		.nearest_distance (nearest_distance),
		.nearest_id       (nearest_id),
		.group_done       (group_done)
	);

endmodule

// ===== test/tb.sv =====
// testbench for the ray/triangle nearest-hit core: random and directed triangles checked
// against an exact integer model of the intersection and the nearest-hit tracking
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rtn_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int DRAIN_CYCLES   = 2000;

	typedef logic signed [255:0] wide_t;

	typedef struct {
		logic [31:0] v[9];
		logic [15:0] id;
		logic        last;
	} triangle_t;

	typedef struct {
		logic        hit;
		logic [30:0] t_dist;
		logic        found;
		logic [30:0] near_dist;
		logic [15:0] near_id;
		logic        done;
	} hit_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [31:0] vtx[9] = '{default: '0};
	logic [15:0] triangle_id = '0;
	logic group_last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic hit;
	logic [30:0] hit_distance;
	logic nearest_found;
	logic [30:0] nearest_distance;
	logic [15:0] nearest_id;
	logic group_done;

	// shadow of the ray and threshold registers
	logic [31:0] ray_org[3];
	logic [31:0] ray_dir[3];
	logic [31:0] det_thr;
	logic [30:0] min_dist;
	// running nearest hit of the current group
	logic        best_found;
	logic [30:0] best_dist;
	logic [15:0] best_id;

	triangle_t   tri_q[$];
	hit_result_t hit_q[$];
	int errors = 0;
	int burst_left = 0;
	int gap_left = 0;
	int ready_left = 0;
	int idle_cycles = 0;

	always #5 clk = ~clk;

	ray_triangle_nearest_hit_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.vertex_a_x(vtx[0]), .vertex_a_y(vtx[1]), .vertex_a_z(vtx[2]),
		.vertex_b_x(vtx[3]), .vertex_b_y(vtx[4]), .vertex_b_z(vtx[5]),
		.vertex_c_x(vtx[6]), .vertex_c_y(vtx[7]), .vertex_c_z(vtx[8]),
		.triangle_id(triangle_id), .group_last(group_last),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .hit_distance(hit_distance),
		.nearest_found(nearest_found), .nearest_distance(nearest_distance),
		.nearest_id(nearest_id), .group_done(group_done)
	);

	function automatic wide_t sext(logic [31:0] x);
		wide_t r;
		r = $signed(x);
		return r;
	endfunction

	// exact moller-trumbore test; returns hit and writes the Q16.16 distance
	function automatic logic intersect_triangle(triangle_t tr, output logic [30:0] t_out);
		wide_t d[3], e1[3], e2[3], tv[3], pv[3], qv[3];
		wide_t det, un, vn, tn, thr, nn, md;
		t_out = '0;
		for (int i = 0; i < 3; i++) begin
			d[i]  = sext(ray_dir[i]);
			e1[i] = sext(tr.v[3+i]) - sext(tr.v[i]);
			e2[i] = sext(tr.v[6+i]) - sext(tr.v[i]);
			tv[i] = sext(ray_org[i]) - sext(tr.v[i]);
		end
		pv[0] = d[1]*e2[2] - d[2]*e2[1];
		pv[1] = d[2]*e2[0] - d[0]*e2[2];
		pv[2] = d[0]*e2[1] - d[1]*e2[0];
		det = e1[0]*pv[0] + e1[1]*pv[1] + e1[2]*pv[2];
		if (det == 0)
			return 1'b0;
		un = tv[0]*pv[0] + tv[1]*pv[1] + tv[2]*pv[2];
		qv[0] = tv[1]*e1[2] - tv[2]*e1[1];
		qv[1] = tv[2]*e1[0] - tv[0]*e1[2];
		qv[2] = tv[0]*e1[1] - tv[1]*e1[0];
		vn = d[0]*qv[0] + d[1]*qv[1] + d[2]*qv[2];
		tn = e2[0]*qv[0] + e2[1]*qv[1] + e2[2]*qv[2];
		if (det < 0) begin
			det = -det; un = -un; vn = -vn; tn = -tn;
		end
		thr = {224'b0, det_thr};
		thr = thr << (2*FRAC_BITS);
		if (det < thr || un < 0 || un > det || vn < 0 || un + vn > det)
			return 1'b0;
		nn = tn << FRAC_BITS;
		md = {225'b0, min_dist};
		md = md * det;
		if (nn < md)
			return 1'b0;
		if (nn >= (det << 31))
			t_out = 31'h7FFFFFFF;
		else
			t_out = 31'(nn / det);
		return 1'b1;
	endfunction

	function automatic hit_result_t track_nearest(triangle_t tr);
		hit_result_t r;
		logic [30:0] t;
		r.hit = intersect_triangle(tr, t);
		r.t_dist = t;
		if (r.hit && (!best_found || t < best_dist)) begin
			best_found = 1'b1;
			best_dist = t;
			best_id = tr.id;
		end
		r.found = best_found;
		r.near_dist = best_dist;
		r.near_id = best_id;
		r.done = tr.last;
		if (tr.last) begin
			best_found = 1'b0;
			best_dist = '0;
			best_id = '0;
		end
		return r;
	endfunction

	task automatic report(string field, logic [31:0] want, logic [31:0] got);
		$display("mismatch %s: expected %h got %h at %0t", field, want, got, $realtime);
		errors++;
	endtask

	// sender: bursts with random gaps, prediction on each accepted beat
	always @(posedge clk) begin
		logic take;
		take = in_valid && in_ready;
		if (take)
			hit_q = {hit_q, track_nearest(tri_q.pop_front())};
		if (arst_n && (!in_valid || take)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (tri_q.size() > 0) begin
				for (int i = 0; i < 9; i++)
					vtx[i] <= tri_q[0].v[i];
				triangle_id <= tri_q[0].id;
				group_last <= tri_q[0].last;
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 12);
					case ($urandom_range(0, 3))
						0: gap_left <= 0;
						1: gap_left <= $urandom_range(1, 8);
						2: gap_left <= $urandom_range(100, 1000);
						default: gap_left <= $urandom_range(0, 1500);
					endcase
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern and result check
	always @(posedge clk) begin
		hit_result_t w;
		if (out_valid && out_ready) begin
			if (hit_q.size() == 0) begin
				report("unexpected beat", 32'd0, 32'd1);
			end else begin
				w = hit_q.pop_front();
				if (hit !== w.hit) report("hit", w.hit, hit);
				if (hit_distance !== w.t_dist) report("hit_distance", w.t_dist, hit_distance);
				if (nearest_found !== w.found) report("nearest_found", w.found, nearest_found);
				if (nearest_distance !== w.near_dist)
					report("nearest_distance", w.near_dist, nearest_distance);
				if (nearest_id !== w.near_id) report("nearest_id", w.near_id, nearest_id);
				if (group_done !== w.done) report("group_done", w.done, group_done);
			end
		end
		if (ready_left > 0) begin
			ready_left <= ready_left - 1;
		end else begin
			out_ready <= ~out_ready;
			if (out_ready)
				ready_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3)
					: $urandom_range(200, 1500);
			else
				ready_left <= $urandom_range(1, 4000);
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_ORIGIN_X: ray_org[0] = value;
			REG_ORIGIN_Y: ray_org[1] = value;
			REG_ORIGIN_Z: ray_org[2] = value;
			REG_DIR_X:    ray_dir[0] = value;
			REG_DIR_Y:    ray_dir[1] = value;
			REG_DIR_Z:    ray_dir[2] = value;
			REG_DET_THR:  det_thr = value;
			REG_MIN_DIST: min_dist = value[30:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
			logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
			logic [31:0] thr, logic [31:0] md);
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_ORIGIN_Z, oz);
		write_reg(REG_DIR_X, dx);
		write_reg(REG_DIR_Y, dy);
		write_reg(REG_DIR_Z, dz);
		write_reg(REG_DET_THR, thr);
		write_reg(REG_MIN_DIST, md & 32'h7FFFFFFF);
	endtask

	function automatic int q16(int k);
		return k * 65536;
	endfunction

	task automatic push_tri(int ax, int ay, int az, int bx, int by, int bz,
			int cx, int cy, int cz, int id, bit last);
		triangle_t tr;
		tr.v = '{ax, ay, az, bx, by, bz, cx, cy, cz};
		tr.id = 16'(id);
		tr.last = last;
		tri_q = {tri_q, tr};
	endtask

	// mostly triangles around a point on the ray, some raw noise
	task automatic push_random(int count);
		triangle_t tr;
		longint s, p;
		int r;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 9) < 3) begin
				for (int i = 0; i < 9; i++)
					tr.v[i] = $urandom;
			end else begin
				s = $urandom_range(0, 64 << 16);
				r = 1 << $urandom_range(4, 22);
				for (int i = 0; i < 3; i++) begin
					p = longint'($signed(ray_org[i])) + ((s * longint'($signed(ray_dir[i]))) >>> 16);
					for (int k = 0; k < 3; k++)
						tr.v[3*k+i] = 32'(p + longint'($urandom_range(0, 2*r)) - r);
				end
			end
			tr.id = 16'($urandom);
			tr.last = ($urandom_range(0, 5) == 0);
			tri_q = {tri_q, tr};
		end
	endtask

	task automatic wait_idle();
		while (tri_q.size() != 0 || in_valid || hit_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] rnd_signed(int r);
		return 32'($urandom_range(0, 2*r) - r);
	endfunction

	initial begin
		ray_org = '{32'd0, 32'd0, 32'd0};
		ray_dir = '{32'd0, 32'd0, 32'd65536};
		det_thr = 32'd1;
		min_dist = 31'd1;
		best_found = 1'b0;
		best_dist = '0;
		best_id = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset ray along +z from the origin
		push_tri(q16(-1), q16(-1), q16(5), q16(3), q16(-1), q16(5), q16(-1), q16(3), q16(5), 1, 0);
		push_tri(q16(-1), q16(-1), q16(7), q16(-1), q16(3), q16(7), q16(3), q16(-1), q16(7), 2, 0);
		push_tri(0, 0, q16(4), q16(2), 0, q16(4), 0, q16(2), q16(4), 3, 0);
		push_tri(q16(-2), 0, q16(3), 0, 0, q16(3), q16(-2), q16(2), q16(3), 4, 0);
		push_tri(q16(-1), q16(-1), q16(6), q16(1), q16(-1), q16(6), q16(-1), q16(1), q16(6), 5, 0);
		push_tri(q16(1), q16(1), q16(5), q16(3), q16(1), q16(5), q16(1), q16(3), q16(5), 6, 0);
		push_tri(0, 0, q16(5), q16(1), q16(1), q16(5), q16(2), q16(2), q16(5), 7, 0);
		push_tri(q16(-1), q16(-1), q16(-5), q16(3), q16(-1), q16(-5), q16(-1), q16(3), q16(-5),
			8, 0);
		push_tri(q16(-1), q16(-1), 0, q16(3), q16(-1), 0, q16(-1), q16(3), 0, 9, 0);
		// distance equal to min_distance, then a tie on t = 3
		push_tri(q16(-1), q16(-1), 1, q16(3), q16(-1), 1, q16(-1), q16(3), 1, 10, 1);
		push_tri(q16(-1), q16(-1), q16(3), q16(3), q16(-1), q16(3), q16(-1), q16(3), q16(3),
			11, 0);
		push_tri(q16(-2), q16(-2), q16(3), q16(4), q16(-2), q16(3), q16(-2), q16(4), q16(3),
			12, 1);
		push_tri(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 1);
		push_tri(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0);
		push_tri(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
			32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hA5A5, 1);
		push_random(300);
		wait_idle();

		// far hit past the Q16.16 range, zero thresholds
		set_ray(0, 0, 32'h80000000, 0, 0, 32'h10000, 0, 0);
		push_tri(q16(-1), q16(-1), q16(1), q16(3), q16(-1), q16(1), q16(-1), q16(3), q16(1), 20, 0);
		push_tri(q16(-1), q16(-1), 32'h80000000, q16(3), q16(-1), 32'h80000000,
			q16(-1), q16(3), 32'h80000000, 21, 1);
		push_random(300);
		wait_idle();

		// extreme ray and thresholds at their maxima
		set_ray(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF);
		push_random(150);
		wait_idle();

		// random moderate rays
		for (int ph = 0; ph < 4; ph++) begin
			set_ray(rnd_signed(1 << 22), rnd_signed(1 << 22), rnd_signed(1 << 22),
				rnd_signed(1 << 18), rnd_signed(1 << 18), rnd_signed(1 << 18),
				$urandom_range(0, 3), $urandom_range(0, 1 << 10));
			push_random(220);
			wait_idle();
		end

		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule
